// ----- hdl/minimum_spanning_tree_kruskal_macros.svh -----
// Assertion macros shared by the spanning tree RTL.
`ifndef MINIMUM_SPANNING_TREE_KRUSKAL_MACROS_SVH
`define MINIMUM_SPANNING_TREE_KRUSKAL_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define MSTK_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("mstk assertion failed");
// Check that a condition is followed by a consequence in the next cycle.
`define MSTK_ASSERT_NEXT(lbl, clk, rst_n, cond, nxt) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) \
    else $error("mstk assertion failed");
`else
`define MSTK_ASSERT(lbl, clk, rst_n, prop)
`define MSTK_ASSERT_NEXT(lbl, clk, rst_n, cond, nxt)
`endif
`endif

// ----- hdl/mstk_pkg.sv -----
// Shared types and constants for the spanning tree block.
`default_nettype none
package mstk_pkg;
  localparam int ENDP_W   = 5;
  localparam int WEIGHT_W = 32;
  localparam int TOTAL_W  = 40;
  localparam int VC_W     = 6;
  localparam int PICK_W   = 5;
  localparam int PICK_CAP = 31;
  localparam int VC_RESET = 32;

  // Input kind codes
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_RUN  = 1'b1;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;
    logic scan_init;
    logic scan_step;
    logic mark;
    logic find_step;
    logic find_a_done;
    logic find_b_done;
    logic size_rd;
    logic merge;
    logic emit_total;
    logic clear;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic scan_done;
    logic found;
    logic p_root;
    logic roots_eq;
    logic out_busy;
    logic out_taken;
  } stat_t;
endpackage
`default_nettype wire

// ----- hdl/mstk_dp.sv -----
// Datapath: edge store, scan for minimum edge, union-find table, result register.
`default_nettype none
`include "minimum_spanning_tree_kruskal_macros.svh"
module mstk_dp import mstk_pkg::*; #(
  parameter int MAX_VERTICES = 32,
  parameter int MAX_EDGES    = 1024
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire cmd_t                       cmd,
  output stat_t                           st,
  input  wire logic [ENDP_W-1:0]          in_a,
  input  wire logic [ENDP_W-1:0]          in_b,
  input  wire logic signed [WEIGHT_W-1:0] in_w,
  input  wire logic                       out_ready,
  output logic                            out_valid,
  output logic                            out_is_total,
  output logic [ENDP_W-1:0]               out_a,
  output logic [ENDP_W-1:0]               out_b,
  output logic signed [WEIGHT_W-1:0]      out_w,
  output logic signed [TOTAL_W-1:0]       out_total,
  output logic                            out_last
);
  localparam int AW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int VW  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int SW  = $clog2(MAX_VERTICES + 1);
  localparam int EW  = 2 * ENDP_W + WEIGHT_W;
  localparam int NEP = 1 << ENDP_W;

  // Edge store and taken marks
  logic [EW-1:0] mem [MAX_EDGES];
  logic          used_mem [MAX_EDGES];
  logic [EW-1:0] edge_q;
  logic          used_q;
  logic [AW-1:0] idx_q;

  logic [AW:0]   fill_r, fill_nxt;
  logic [AW:0]   addr_r, addr_nxt;
  logic          rd_v_r, rd_v_nxt;
  logic          found_r, found_nxt;
  logic [AW-1:0] best_idx_r, best_idx_nxt;
  logic [ENDP_W-1:0] best_a_r, best_a_nxt, best_b_r, best_b_nxt;
  logic signed [WEIGHT_W-1:0] best_w_r, best_w_nxt;

  // Union-find tables with valid bits; invalid entries read as reset value
  logic [VW-1:0] par_r [MAX_VERTICES];
  logic [SW-1:0] sz_r  [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] pv_r, pv_nxt, sv_r, sv_nxt;
  logic [VW-1:0] r_r, r_nxt, ra_r, ra_nxt, rb_r, rb_nxt;
  logic [SW-1:0] sa_r, sa_nxt;
  logic [VW-1:0] modtab [NEP];

  logic signed [TOTAL_W-1:0] sum_r, sum_nxt;
  logic out_valid_r, out_valid_nxt;

  logic          full, mem_we, used_we, used_wd, less;
  logic [AW-1:0] used_wa;
  logic [ENDP_W-1:0] aq, bq;
  logic signed [WEIGHT_W-1:0] wq;
  logic [VW-1:0] p_val;
  logic [SW-1:0] sb_val, sz_sum;

  // Endpoint to table index, reduced at elaboration
  for (genvar g = 0; g < NEP; g++) begin : g_mod
    assign modtab[g] = VW'(g % MAX_VERTICES);
  end

  assign full    = (fill_r == (AW+1)'(MAX_EDGES));
  assign mem_we  = cmd.load && !full;
  assign used_we = mem_we || cmd.mark;
  assign used_wa = cmd.mark ? best_idx_r : fill_r[AW-1:0];
  assign used_wd = cmd.mark;
  assign {wq, bq, aq} = edge_q;

  // Store writes and registered scan reads
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[fill_r[AW-1:0]] <= {in_w, in_b, in_a};
    end
    if (used_we) begin
      used_mem[used_wa] <= used_wd;
    end
    edge_q <= mem[addr_r[AW-1:0]];
    used_q <= used_mem[addr_r[AW-1:0]];
    idx_q  <= addr_r[AW-1:0];
  end

  // Key order: weight, then first endpoint, then second endpoint
  always_comb begin
    less = (wq < best_w_r) ||
           ((wq == best_w_r) && ((aq < best_a_r) || ((aq == best_a_r) && (bq < best_b_r))));
  end

  assign p_val  = pv_r[r_r] ? par_r[r_r] : r_r;
  assign sb_val = sv_r[rb_r] ? sz_r[rb_r] : SW'(1);
  assign sz_sum = sa_r + sb_val;

  // Next-state logic of the datapath
  always_comb begin
    fill_nxt      = fill_r;
    addr_nxt      = addr_r;
    rd_v_nxt      = rd_v_r;
    found_nxt     = found_r;
    best_idx_nxt  = best_idx_r;
    best_a_nxt    = best_a_r;
    best_b_nxt    = best_b_r;
    best_w_nxt    = best_w_r;
    pv_nxt        = pv_r;
    sv_nxt        = sv_r;
    r_nxt         = r_r;
    ra_nxt        = ra_r;
    rb_nxt        = rb_r;
    sa_nxt        = sa_r;
    sum_nxt       = sum_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (mem_we) begin
      fill_nxt = fill_r + 1'b1;
    end
    if (cmd.scan_init) begin
      addr_nxt  = '0;
      rd_v_nxt  = 1'b0;
      found_nxt = 1'b0;
    end
    if (cmd.scan_step) begin
      rd_v_nxt = (addr_r < fill_r);
      if (addr_r < fill_r) begin
        addr_nxt = addr_r + 1'b1;
      end
      if (rd_v_r && !used_q && (!found_r || less)) begin
        found_nxt    = 1'b1;
        best_idx_nxt = idx_q;
        best_a_nxt   = aq;
        best_b_nxt   = bq;
        best_w_nxt   = wq;
      end
    end
    if (cmd.mark) begin
      r_nxt = modtab[best_a_r];
    end
    if (cmd.find_step) begin
      r_nxt = p_val;
    end
    if (cmd.find_a_done) begin
      ra_nxt = r_r;
      r_nxt  = modtab[best_b_r];
    end
    if (cmd.find_b_done) begin
      rb_nxt = r_r;
    end
    if (cmd.size_rd) begin
      sa_nxt = sv_r[ra_r] ? sz_r[ra_r] : SW'(1);
    end
    if (cmd.merge) begin
      if (sa_r > sb_val) begin
        pv_nxt[rb_r] = 1'b1;
        sv_nxt[ra_r] = 1'b1;
      end else begin
        pv_nxt[ra_r] = 1'b1;
        sv_nxt[rb_r] = 1'b1;
      end
      sum_nxt       = sum_r + TOTAL_W'(best_w_r);
      out_valid_nxt = 1'b1;
    end
    if (cmd.emit_total) begin
      out_valid_nxt = 1'b1;
    end
    if (cmd.clear) begin
      fill_nxt = '0;
      pv_nxt   = '0;
      sv_nxt   = '0;
      sum_nxt  = '0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      addr_r      <= '0;
      rd_v_r      <= 1'b0;
      found_r     <= 1'b0;
      pv_r        <= '0;
      sv_r        <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      fill_r      <= fill_nxt;
      addr_r      <= addr_nxt;
      rd_v_r      <= rd_v_nxt;
      found_r     <= found_nxt;
      pv_r        <= pv_nxt;
      sv_r        <= sv_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    best_idx_r <= best_idx_nxt;
    best_a_r   <= best_a_nxt;
    best_b_r   <= best_b_nxt;
    best_w_r   <= best_w_nxt;
    r_r        <= r_nxt;
    ra_r       <= ra_nxt;
    rb_r       <= rb_nxt;
    sa_r       <= sa_nxt;
    if (cmd.merge) begin
      if (sa_r > sb_val) begin
        par_r[rb_r] <= ra_r;
        sz_r[ra_r]  <= sz_sum;
      end else begin
        par_r[ra_r] <= rb_r;
        sz_r[rb_r]  <= sz_sum;
      end
      out_is_total <= 1'b0;
      out_a        <= best_a_r;
      out_b        <= best_b_r;
      out_w        <= best_w_r;
      out_total    <= sum_nxt;
      out_last     <= 1'b0;
    end
    if (cmd.emit_total) begin
      out_is_total <= 1'b1;
      out_a        <= '0;
      out_b        <= '0;
      out_w        <= '0;
      out_total    <= sum_r;
      out_last     <= 1'b1;
    end
  end

  assign out_valid = out_valid_r;

  // Status to the controller
  always_comb begin
    st.scan_done = (addr_r == fill_r) && !rd_v_r;
    st.found     = found_r;
    st.p_root    = (p_val == r_r);
    st.roots_eq  = (ra_r == rb_r);
    st.out_busy  = out_valid_r;
    st.out_taken = out_valid_r && out_ready;
  end

  `MSTK_ASSERT(a_fill_bound, clk, rst_n, fill_r <= (AW+1)'(MAX_EDGES))
  `MSTK_ASSERT(a_merge_roots, clk, rst_n, !cmd.merge || (ra_r != rb_r))
  `MSTK_ASSERT_NEXT(a_total_shown, clk, rst_n, cmd.emit_total, out_valid_r && out_last)
endmodule
`default_nettype wire

// ----- hdl/mstk_ctrl.sv -----
// Controller: sequences loads, scans, root finds, merges and result transfers.
`default_nettype none
`include "minimum_spanning_tree_kruskal_macros.svh"
module mstk_ctrl import mstk_pkg::*; #(
  parameter int MAX_VERTICES = 32
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  input  wire logic            in_kind,
  output logic                 in_ready,
  input  wire logic [VC_W-1:0] vertex_count,
  input  wire stat_t           st,
  output cmd_t                 cmd
);
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SCAN   = 4'd1;
  localparam logic [3:0] S_FIND_A = 4'd2;
  localparam logic [3:0] S_FIND_B = 4'd3;
  localparam logic [3:0] S_CHECK  = 4'd4;
  localparam logic [3:0] S_MERGE  = 4'd5;
  localparam logic [3:0] S_WAIT_E = 4'd6;
  localparam logic [3:0] S_WAIT_T = 4'd7;

  logic [3:0]        state_r, state_nxt;
  logic [PICK_W:0]   picked_r, picked_nxt;
  logic [PICK_W:0]   limit_r, limit_nxt;
  logic [VC_W:0]     vc_clip, lim_w;
  logic              in_fire;

  // Pick limit from vertex count
  always_comb begin
    vc_clip = ({1'b0, vertex_count} > (VC_W+1)'(MAX_VERTICES)) ?
              (VC_W+1)'(MAX_VERTICES) : {1'b0, vertex_count};
    lim_w   = (vc_clip < (VC_W+1)'(2)) ? '0 : vc_clip - 1'b1;
    if (lim_w > (VC_W+1)'(PICK_CAP)) begin
      lim_w = (VC_W+1)'(PICK_CAP);
    end
  end

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;

  // State transitions and commands
  always_comb begin
    state_nxt  = state_r;
    picked_nxt = picked_r;
    limit_nxt  = limit_r;
    cmd        = '0;
    case (state_r)
      S_IDLE: begin
        if (in_fire && (in_kind == KIND_LOAD)) begin
          cmd.load = 1'b1;
        end
        if (in_fire && (in_kind == KIND_RUN)) begin
          limit_nxt  = (PICK_W+1)'(lim_w);
          picked_nxt = '0;
          if (lim_w == '0) begin
            cmd.emit_total = 1'b1;
            state_nxt      = S_WAIT_T;
          end else begin
            cmd.scan_init = 1'b1;
            state_nxt     = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (st.scan_done) begin
          if (st.found) begin
            cmd.mark  = 1'b1;
            state_nxt = S_FIND_A;
          end else begin
            cmd.emit_total = 1'b1;
            state_nxt      = S_WAIT_T;
          end
        end
      end
      S_FIND_A: begin
        if (st.p_root) begin
          cmd.find_a_done = 1'b1;
          state_nxt       = S_FIND_B;
        end else begin
          cmd.find_step = 1'b1;
        end
      end
      S_FIND_B: begin
        if (st.p_root) begin
          cmd.find_b_done = 1'b1;
          state_nxt       = S_CHECK;
        end else begin
          cmd.find_step = 1'b1;
        end
      end
      S_CHECK: begin
        if (st.roots_eq) begin
          cmd.scan_init = 1'b1;
          state_nxt     = S_SCAN;
        end else begin
          cmd.size_rd = 1'b1;
          state_nxt   = S_MERGE;
        end
      end
      S_MERGE: begin
        cmd.merge = 1'b1;
        state_nxt = S_WAIT_E;
      end
      S_WAIT_E: begin
        if (st.out_taken) begin
          picked_nxt = picked_r + 1'b1;
          if ((picked_r + 1'b1) < limit_r) begin
            cmd.scan_init = 1'b1;
            state_nxt     = S_SCAN;
          end else begin
            cmd.emit_total = 1'b1;
            state_nxt      = S_WAIT_T;
          end
        end
      end
      S_WAIT_T: begin
        if (st.out_taken) begin
          cmd.clear = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      picked_r <= '0;
      limit_r  <= '0;
    end else begin
      state_r  <= state_nxt;
      picked_r <= picked_nxt;
      limit_r  <= limit_nxt;
    end
  end

  `MSTK_ASSERT(a_idle_out_free, clk, rst_n, (state_r != S_IDLE) || !st.out_busy)
  `MSTK_ASSERT(a_pick_bound, clk, rst_n, (state_r == S_IDLE) || (picked_r <= limit_r))
  `MSTK_ASSERT_NEXT(a_find_flow, clk, rst_n, state_r == S_FIND_A,
                    (state_r == S_FIND_A) || (state_r == S_FIND_B))
endmodule
`default_nettype wire

// ----- hdl/minimum_spanning_tree_kruskal.sv -----
// Top level of the Kruskal spanning tree block.
//
//  channel | direction | handshake          | payload
//  in_     | slave     | in_tvalid/tready   | tuser kind, tdata edge
//  out_    | master    | out_tvalid/tready  | tuser is_total, tdata edge+total, tlast
//  cfg_    | slave     | cfg_valid/ready    | cfg_data vertex_count
//
// The block takes a load on every cycle while idle.
// For each edge considered, a run scans the store (one read port), then follows the parent
// hops of each endpoint until it sees its root, then checks the two roots; a picked edge
// adds a size read, a merge step and a stay in the output register.
// Each result waits in the output register until transferred; the run stalls meanwhile.
// Reset (rst_n, synchronous) empties the store and sets vertex_count to 32; no clearing pass.
`default_nettype none
module minimum_spanning_tree_kruskal import mstk_pkg::*; #(
  parameter int MAX_VERTICES = 32,
  parameter int MAX_EDGES    = 1024
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_tvalid,
  output logic                 in_tready,
  input  wire logic [47:0]     in_tdata,   // end_a[4:0], end_b[9:5], edge_weight[41:10]
  input  wire logic            in_tuser,   // kind[0]
  output logic                 out_tvalid,
  input  wire logic            out_tready,
  output logic [87:0]          out_tdata,  // pick_a[4:0], pick_b[9:5], pick_weight[41:10],
                                           // tree_total[81:42]
  output logic                 out_tuser,  // is_total[0]
  output logic                 out_tlast,
  input  wire logic            cfg_valid,
  output logic                 cfg_ready,
  input  wire logic [VC_W-1:0] cfg_data
);
  cmd_t  cmd;
  stat_t st;
  logic [VC_W-1:0] vc_r;
  logic [ENDP_W-1:0] oa, ob;
  logic signed [WEIGHT_W-1:0] ow;
  logic signed [TOTAL_W-1:0]  ot;

  // Hold the vertex count register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= VC_W'(VC_RESET);
    end else if (cfg_valid) begin
      vc_r <= cfg_data;
    end
  end

  mstk_ctrl #(.MAX_VERTICES(MAX_VERTICES)) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_kind      (in_tuser),
    .in_ready     (in_tready),
    .vertex_count (vc_r),
    .st           (st),
    .cmd          (cmd)
  );

  mstk_dp #(.MAX_VERTICES(MAX_VERTICES), .MAX_EDGES(MAX_EDGES)) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .st           (st),
    .in_a         (in_tdata[4:0]),
    .in_b         (in_tdata[9:5]),
    .in_w         (in_tdata[41:10]),
    .out_ready    (out_tready),
    .out_valid    (out_tvalid),
    .out_is_total (out_tuser),
    .out_a        (oa),
    .out_b        (ob),
    .out_w        (ow),
    .out_total    (ot),
    .out_last     (out_tlast)
  );

  assign out_tdata = {6'd0, ot, ow, ob, oa};
endmodule
`default_nettype wire
